>>> hdl/rolling_hash_pattern_matcher_unit_assert.svh
// Assertion macros used by the checker file.
`ifndef ROLLING_HASH_PATTERN_MATCHER_UNIT_ASSERT_SVH
`define ROLLING_HASH_PATTERN_MATCHER_UNIT_ASSERT_SVH

// same-cycle implication
`define RHPM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RHPM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/rhpm_pkg.sv
`timescale 1ns / 1ps

package rhpm_pkg;

  localparam int MaxPattern = 16;
  localparam int HashPrime  = 13;
  localparam int CellIdxW   = $clog2(MaxPattern);
  localparam int LenW       = $clog2(MaxPattern) + 1;
  localparam int HashW      = $clog2(HashPrime);
  localparam int ModInW     = 16;
  localparam int ModShift   = 16;
  localparam int ModRecip   = (1 << ModShift) / HashPrime;
  localparam int SumBias    = HashPrime * (HashPrime - 1);
  localparam int SeenW      = 17;
  localparam int OffsetW    = 16;
  localparam int CfgIdxW    = 3;
  localparam int BaseReset  = 256;

  localparam logic [CfgIdxW-1:0] CfgPatLo    = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgPatHi    = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgPatLen   = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgHashBase = 3'd3;

  typedef struct packed {
    logic                  busy;
    logic                  restart;
    logic [LenW-1:0]       len;
    logic [CellIdxW-1:0]   last_idx;
    logic [HashW-1:0]      pat_hash;
    logic [HashW-1:0]      base_mod;
    logic [HashW-1:0]      roll_w;
    logic [MaxPattern-1:0] pat_load;
    logic [7:0]            pat_byte;
  } rhpm_ctl_t;

  // residue by reciprocal multiply, quotient low by at most one
  function automatic logic [HashW-1:0] mod_prime(input logic [ModInW-1:0] v);
    logic [ModInW+ModShift-1:0] prod;
    logic [ModInW-1:0]          q;
    logic [ModInW-1:0]          r;
    prod = (ModInW+ModShift)'(v) * (ModInW+ModShift)'(ModRecip);
    q    = ModInW'(prod >> ModShift);
    r    = v - ModInW'(q * ModInW'(HashPrime));
    if (r >= ModInW'(HashPrime)) begin
      r = r - ModInW'(HashPrime);
    end
    return r[HashW-1:0];
  endfunction

endpackage

>>> hdl/rhpm_cell.sv
`timescale 1ns / 1ps

module rhpm_cell
  import rhpm_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             shift_i,
  input  logic [7:0]       byte_i,
  input  logic [HashW-1:0] res_i,
  input  logic             load_i,
  input  logic [7:0]       pat_i,
  output logic [7:0]       byte_o,
  output logic [HashW-1:0] res_o,
  output logic             hit_o
);

  logic [7:0]       byte_q;
  logic [HashW-1:0] res_q;
  logic [7:0]       pat_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      byte_q <= byte_i;
      res_q  <= res_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_q <= '0;
    end else if (load_i) begin
      pat_q <= pat_i;
    end
  end

  // compare on the byte this cell takes with the shift
  assign hit_o  = (byte_i == pat_q);
  assign byte_o = byte_q;
  assign res_o  = res_q;

endmodule

>>> hdl/rhpm_cfg.sv
`timescale 1ns / 1ps

module rhpm_cfg
  import rhpm_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [63:0]        cfg_data_i,
  output rhpm_ctl_t          ctl_o
);

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StPrep = 3'b010,
    StStep = 3'b100
  } drv_state_e;

  drv_state_e          state_q, state_d;
  logic [63:0]         pat_lo_q, pat_lo_d;
  logic [63:0]         pat_hi_q, pat_hi_d;
  logic [4:0]          len_q, len_d;
  logic [15:0]         base_q, base_d;
  logic [HashW-1:0]    base_mod_q, base_mod_d;
  logic [HashW-1:0]    ph_q, ph_d;
  logic [HashW-1:0]    pw_q, pw_d;
  logic [CellIdxW-1:0] step_q, step_d;

  logic [LenW-1:0]       len_eff;
  logic [CellIdxW-1:0]   last_idx;
  logic [127:0]          pat_all;
  logic [7:0]            cur_byte;
  logic                  wr;
  logic [MaxPattern-1:0] pat_load;
  logic [CellIdxW-1:0]   load_idx;

  always_comb begin
    if (len_q == '0) begin
      len_eff = LenW'(1);
    end else if (LenW'(len_q) > LenW'(MaxPattern)) begin
      len_eff = LenW'(MaxPattern);
    end else begin
      len_eff = LenW'(len_q);
    end
  end

  assign last_idx = CellIdxW'(len_eff - LenW'(1));
  assign pat_all  = {pat_hi_q, pat_lo_q};
  assign cur_byte = pat_all[{step_q, 3'b000} +: 8];
  assign load_idx = last_idx - step_q;

  always_comb begin
    state_d    = state_q;
    pat_lo_d   = pat_lo_q;
    pat_hi_d   = pat_hi_q;
    len_d      = len_q;
    base_d     = base_q;
    base_mod_d = base_mod_q;
    ph_d       = ph_q;
    pw_d       = pw_q;
    step_d     = step_q;
    wr         = 1'b0;
    pat_load   = '0;
    unique case (state_q)
      StIdle: begin
        if (cfg_valid_i) begin
          wr = 1'b1;
          unique case (cfg_index_i)
            CfgPatLo:    pat_lo_d = cfg_data_i;
            CfgPatHi:    pat_hi_d = cfg_data_i;
            CfgPatLen:   len_d    = cfg_data_i[4:0];
            CfgHashBase: base_d   = cfg_data_i[15:0];
            default:     wr       = 1'b0;
          endcase
          if (wr) begin
            state_d = StPrep;
          end
        end
      end
      StPrep: begin
        base_mod_d = mod_prime(base_q);
        ph_d       = '0;
        pw_d       = HashW'(1);
        step_d     = '0;
        state_d    = StStep;
      end
      StStep: begin
        // Horner step for the pattern hash; pw ends as base^len
        ph_d = mod_prime(ModInW'(ph_q) * ModInW'(base_mod_q) + ModInW'(cur_byte));
        pw_d = mod_prime(ModInW'(pw_q) * ModInW'(base_mod_q));
        pat_load[load_idx] = 1'b1;
        if (step_q == last_idx) begin
          state_d = StIdle;
        end else begin
          step_d = step_q + CellIdxW'(1);
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      pat_lo_q   <= '0;
      pat_hi_q   <= '0;
      len_q      <= 5'd1;
      base_q     <= 16'(BaseReset);
      base_mod_q <= HashW'(BaseReset % HashPrime);
      ph_q       <= '0;
      pw_q       <= HashW'(BaseReset % HashPrime);
      step_q     <= '0;
    end else begin
      state_q    <= state_d;
      pat_lo_q   <= pat_lo_d;
      pat_hi_q   <= pat_hi_d;
      len_q      <= len_d;
      base_q     <= base_d;
      base_mod_q <= base_mod_d;
      ph_q       <= ph_d;
      pw_q       <= pw_d;
      step_q     <= step_d;
    end
  end

  assign cfg_ready_o = (state_q == StIdle);

  always_comb begin
    ctl_o          = '0;
    ctl_o.busy     = (state_q != StIdle);
    ctl_o.restart  = wr;
    ctl_o.len      = len_eff;
    ctl_o.last_idx = last_idx;
    ctl_o.pat_hash = ph_q;
    ctl_o.base_mod = base_mod_q;
    ctl_o.roll_w   = pw_q;
    ctl_o.pat_load = pat_load;
    ctl_o.pat_byte = cur_byte;
  end

endmodule

>>> hdl/rolling_hash_pattern_matcher_unit.sv
`timescale 1ns / 1ps
// channel | direction | handshake                 | payload
// in      | sink      | in_valid_i / in_stall_o   | text_byte_i, start_text_i
// out     | source    | out_valid_o / out_stall_i | match_offset_o
// cfg     | sink      | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// One item per cycle while in_stall_o is low; a match's offset is registered
// into the output queue. A register write starts a derive pass, a prep step
// then one Horner step per cycle; items and writes wait until it ends.
// Reset gives pattern length 1, base 256, all-zero pattern, empty text.
// A two-entry output queue holds results; input also stalls while it is full.

module rolling_hash_pattern_matcher_unit
  import rhpm_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         text_byte_i,
  input  logic               start_text_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [OffsetW-1:0] match_offset_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [63:0]        cfg_data_i
);

  rhpm_ctl_t ctl;

  rhpm_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .ctl_o       (ctl)
  );

  logic                  accept;
  logic [7:0]            cell_byte [MaxPattern];
  logic [HashW-1:0]      cell_res  [MaxPattern];
  logic [MaxPattern-1:0] cell_hit;
  logic [MaxPattern-1:0] cell_ok;
  logic [HashW-1:0]      in_res;

  assign accept = in_valid_i && !in_stall_o;
  assign in_res = mod_prime(ModInW'(text_byte_i));

  for (genvar k = 0; k < MaxPattern; k++) begin : g_cell
    if (k == 0) begin : g_head
      rhpm_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .shift_i (accept),
        .byte_i  (text_byte_i),
        .res_i   (in_res),
        .load_i  (ctl.pat_load[k]),
        .pat_i   (ctl.pat_byte),
        .byte_o  (cell_byte[k]),
        .res_o   (cell_res[k]),
        .hit_o   (cell_hit[k])
      );
    end else begin : g_body
      rhpm_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .shift_i (accept),
        .byte_i  (cell_byte[k-1]),
        .res_i   (cell_res[k-1]),
        .load_i  (ctl.pat_load[k]),
        .pat_i   (ctl.pat_byte),
        .byte_o  (cell_byte[k]),
        .res_o   (cell_res[k]),
        .hit_o   (cell_hit[k])
      );
    end
    assign cell_ok[k] = cell_hit[k] || (LenW'(k) >= ctl.len);
  end

  logic [SeenW-1:0]    seen_q, seen_d;
  logic [HashW-1:0]    wh_q, wh_d;
  logic [SeenW-1:0]    seen_eff, seen_next, off_full;
  logic [HashW-1:0]    wh_eff, old_res;
  logic                full_before;
  logic [ModInW-1:0]   p_keep, p_drop, sum;
  logic                match;
  logic [OffsetW-1:0]  off;

  always_comb begin
    seen_eff    = start_text_i ? '0 : seen_q;
    wh_eff      = start_text_i ? '0 : wh_q;
    full_before = (seen_eff >= SeenW'(ctl.len));
    old_res     = cell_res[ctl.last_idx];
    p_keep      = ModInW'(ctl.base_mod) * ModInW'(wh_eff);
    p_drop      = full_before ? ModInW'(ctl.roll_w) * ModInW'(old_res) : '0;
    sum         = p_keep + ModInW'(text_byte_i) + ModInW'(SumBias) - p_drop;
    seen_next   = (seen_eff == '1) ? seen_eff : seen_eff + SeenW'(1);
    off_full    = seen_next - SeenW'(ctl.len);
    off         = (off_full[SeenW-1:OffsetW] != '0) ? '1 : off_full[OffsetW-1:0];
  end

  logic [HashW-1:0] wh_new;
  assign wh_new = mod_prime(sum);
  assign match  = (seen_next >= SeenW'(ctl.len)) && (wh_new == ctl.pat_hash) && (&cell_ok);

  always_comb begin
    seen_d = seen_q;
    wh_d   = wh_q;
    if (ctl.restart) begin
      seen_d = '0;
      wh_d   = '0;
    end else if (accept) begin
      seen_d = seen_next;
      wh_d   = wh_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= '0;
      wh_q   <= '0;
    end else begin
      seen_q <= seen_d;
      wh_q   <= wh_d;
    end
  end

  // two-entry result queue
  logic [OffsetW-1:0] ent_q [2];
  logic               wr_ptr_q, rd_ptr_q;
  logic [1:0]         cnt_q;
  logic               push, pop;

  assign push = accept && match;
  assign pop  = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wr_ptr_q] <= off;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  assign out_valid_o    = (cnt_q != '0);
  assign match_offset_o = ent_q[rd_ptr_q];
  assign in_stall_o     = ctl.busy || (cnt_q == 2'd2);

endmodule

>>> hdl/rhpm_checker.sv
`timescale 1ns / 1ps
`include "rolling_hash_pattern_matcher_unit_assert.svh"

module rhpm_checker
  import rhpm_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [OffsetW-1:0] match_offset_o,
  input logic               cfg_valid_i,
  input logic               cfg_ready_o,
  input logic [CfgIdxW-1:0] cfg_index_i
);

  logic cfg_fire;
  assign cfg_fire = cfg_valid_i && cfg_ready_o && (cfg_index_i <= CfgHashBase);

  `RHPM_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
    out_valid_o && $stable(match_offset_o), "stalled result changed")

  `RHPM_ASSERT_NEXT(a_write_blocks, clk_i, rst_ni, cfg_fire,
    in_stall_o && !cfg_ready_o, "items not held after register write")

  `RHPM_ASSERT_NOW(a_busy_stall, clk_i, rst_ni, !cfg_ready_o,
    in_stall_o, "item taken during derive pass")

endmodule

bind rolling_hash_pattern_matcher_unit rhpm_checker u_rhpm_checker (.*);
